### rtl/core/dense_graph_mst_weight_core_assert.svh
// Assertion macros for the MST weight core.
`ifndef DENSE_GRAPH_MST_WEIGHT_CORE_ASSERT_SVH
`define DENSE_GRAPH_MST_WEIGHT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define DGMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgmst: implication check failed");
// antecedent implies consequent in the next cycle
`define DGMST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgmst: next-cycle check failed");
`else
`define DGMST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DGMST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/dgmst_pkg.sv
package dgmst_pkg;

    localparam int VERTEX_BITS    = 5;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int TOTAL_BITS     = 21;
    localparam int CFG_BITS       = 6;

    localparam logic [CFG_BITS-1:0]   NUM_VERTICES_RESET = 6'd32;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX          = '1;

    // request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic [VERTEX_BITS-1:0]    vertex_a;
        logic [VERTEX_BITS-1:0]    vertex_b;
        logic [WEIGHT_IN_BITS-1:0] weight;
    } req_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_weight;
        logic                  disconnected;
    } rsp_t;

    // broadcast commands from the sequencer to every cell
    typedef struct packed {
        logic init;   // start of a run: clear tree flag, reload key
        logic mark;   // the cell named by pick joins the tree
        logic relax;  // lower key from the row word read last cycle
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEARCH,
        ST_SELECT,
        ST_RELAX,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/dgmst_cell.sv
// One vertex: its tree flag, its key, its column of the weight matrix,
// and one stage of the minimum-search chain.
module dgmst_cell #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16,
    parameter int IDX          = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dgmst_pkg::cell_cmd_t              cmd,
    input  logic                              active,
    input  logic [$clog2(MAX_VERTICES)-1:0]   pick,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
    input  logic [WEIGHT_BITS-1:0]            wr_data,
    input  logic                              cand_found_in,
    input  logic [WEIGHT_BITS:0]              cand_key_in,
    input  logic [$clog2(MAX_VERTICES)-1:0]   cand_idx_in,
    output logic                              cand_found,
    output logic [WEIGHT_BITS:0]              cand_key,
    output logic [$clog2(MAX_VERTICES)-1:0]   cand_idx
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int KW = WEIGHT_BITS + 1;
    localparam logic [AW-1:0] MY_IDX  = AW'(IDX);
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    logic [WEIGHT_BITS-1:0] mem [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    logic          in_tree_reg, in_tree_next;
    logic [KW-1:0] key_reg, key_next;

    logic          cand_found_reg, cand_found_next;
    logic [KW-1:0] cand_key_reg, cand_key_next;
    logic [AW-1:0] cand_idx_reg, cand_idx_next;

    logic eligible;
    logic take_own;
    logic relax_hit;

    // column storage: entry p holds weight(p, IDX)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[pick];
    end

    assign relax_hit = (rd_data_reg != '0) && !in_tree_reg
                       && ({1'b0, rd_data_reg} < key_reg);

    always_comb
    begin
        in_tree_next = in_tree_reg;
        key_next     = key_reg;
        priority if (cmd.init)
        begin
            in_tree_next = 1'b0;
            key_next     = (MY_IDX == '0) ? '0 : KEY_INF;
        end
        else if (cmd.mark && (pick == MY_IDX))
        begin
            in_tree_next = 1'b1;
        end
        else if (cmd.relax && relax_hit)
        begin
            key_next = {1'b0, rd_data_reg};
        end
    end

    // search stage: lower index upstream wins ties, so own key must be strictly smaller
    assign eligible = active && !in_tree_reg;
    assign take_own = eligible && (!cand_found_in || (key_reg < cand_key_in));

    always_comb
    begin
        if (take_own)
        begin
            cand_found_next = 1'b1;
            cand_key_next   = key_reg;
            cand_idx_next   = MY_IDX;
        end
        else
        begin
            cand_found_next = cand_found_in;
            cand_key_next   = cand_key_in;
            cand_idx_next   = cand_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg    <= 1'b0;
            key_reg        <= KEY_INF;
            cand_found_reg <= 1'b0;
        end
        else
        begin
            in_tree_reg    <= in_tree_next;
            key_reg        <= key_next;
            cand_found_reg <= cand_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_key_reg <= cand_key_next;
        cand_idx_reg <= cand_idx_next;
    end

    assign cand_found = cand_found_reg;
    assign cand_key   = cand_key_reg;
    assign cand_idx   = cand_idx_reg;

endmodule

### rtl/core/dense_graph_mst_weight_core.sv
// Minimum spanning tree weight engine (Prim's method on an adjacency matrix).
// Requests: op ADD writes weight(a,b) and weight(b,a) together (zero removes the edge,
// endpoints at or beyond MAX_VERTICES are dropped); op CLEAR zeroes the matrix in one pass
// over its rows; op RUN builds the tree from vertex 0 over the first num_vertices
// vertices and returns one response: the total weight (saturating at 2^21-1) and a
// disconnected flag, set when some vertex could not be reached, in which case the total
// covers only the reached part. Other opcodes are dropped. ADD and CLEAR give no response.
// After reset the same clearing pass runs with req_ready low.
// RUN works in rounds: every round pushes a candidate down a chain of MAX_VERTICES
// cells (one cell per cycle) to find the cheapest vertex, then commits it and reads
// its matrix row from all cells at once, then relaxes all keys in parallel.
// Each cell holds one vertex's key, tree flag and matrix column.
// A finished response sits in an output register; new ADD/CLEAR requests are accepted
// while it waits, and a following RUN holds its result until the register frees up.
// cfg_num_vertices is always accepted; 0 counts as 1, values above MAX_VERTICES clamp.
`include "dense_graph_mst_weight_core_assert.svh"

module dense_graph_mst_weight_core #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dgmst_pkg::CFG_BITS-1:0]      cfg_num_vertices,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  dgmst_pkg::req_t                     req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output dgmst_pkg::rsp_t                     rsp
);

    localparam int AW  = $clog2(MAX_VERTICES);       // vertex index width
    localparam int NW  = $clog2(MAX_VERTICES + 1);   // vertex count width
    localparam int KW  = WEIGHT_BITS + 1;            // key width, MSB = infinity
    localparam int TB  = dgmst_pkg::TOTAL_BITS;
    localparam int SW  = ((TB > KW) ? TB : KW) + 1;  // total + key before saturation
    localparam int VW  = dgmst_pkg::VERTEX_BITS;
    localparam int WIN = dgmst_pkg::WEIGHT_IN_BITS;
    localparam int CB  = dgmst_pkg::CFG_BITS;
    localparam logic [AW-1:0] CNT_LAST = AW'(MAX_VERTICES - 1);

    // ---------------- configuration ----------------
    logic [CB-1:0] nv_reg;
    logic [NW-1:0] n_eff;
    logic [NW+CB-1:0] nv_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= dgmst_pkg::NUM_VERTICES_RESET;
        end
        else if (cfg_valid)
        begin
            nv_reg <= cfg_num_vertices;
        end
    end

    // clamp the vertex count into 1 .. MAX_VERTICES
    assign nv_wide = {{NW{1'b0}}, nv_reg};
    always_comb
    begin
        priority if (nv_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(nv_reg) > MAX_VERTICES)
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = nv_wide[NW-1:0];
        end
    end

    // ---------------- request decode ----------------
    logic [AW+VW-1:0]         a_wide, b_wide;
    logic [AW-1:0]            a_addr, b_addr;
    logic                     edge_ok;
    logic [WIN+WEIGHT_BITS-1:0] w_wide;
    logic [WEIGHT_BITS-1:0]   w_store;

    assign a_wide  = {{AW{1'b0}}, req.vertex_a};
    assign b_wide  = {{AW{1'b0}}, req.vertex_b};
    assign a_addr  = a_wide[AW-1:0];
    assign b_addr  = b_wide[AW-1:0];
    assign edge_ok = (int'(req.vertex_a) < MAX_VERTICES)
                     && (int'(req.vertex_b) < MAX_VERTICES);
    assign w_wide  = {{WEIGHT_BITS{1'b0}}, req.weight};
    assign w_store = w_wide[WEIGHT_BITS-1:0];

    // ---------------- sequencer state ----------------
    dgmst_pkg::state_t state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [TB-1:0]     total_reg, total_next;
    logic              disc_reg, disc_next;
    logic              rsp_valid_reg, rsp_valid_next;
    dgmst_pkg::rsp_t   rsp_reg;

    dgmst_pkg::cell_cmd_t cmd;
    logic                 clear_we;
    logic                 add_we;
    logic                 load_rsp;

    // search chain links: entry i feeds cell i, entry i+1 is its output
    logic          cf [MAX_VERTICES+1];
    logic [KW-1:0] ck [MAX_VERTICES+1];
    logic [AW-1:0] ci [MAX_VERTICES+1];

    logic [MAX_VERTICES-1:0] active;
    logic                    best_found;
    logic [KW-1:0]           best_key;
    logic [AW-1:0]           best_idx;
    logic [SW-1:0]           sum_wide;
    logic [TB-1:0]           total_sat;

    assign best_found = cf[MAX_VERTICES];
    assign best_key   = ck[MAX_VERTICES];
    assign best_idx   = ci[MAX_VERTICES];

    assign sum_wide  = SW'(total_reg) + SW'(best_key);
    assign total_sat = (sum_wide > SW'(dgmst_pkg::TOTAL_MAX)) ? dgmst_pkg::TOTAL_MAX
                                                              : sum_wide[TB-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        disc_next  = disc_reg;
        cmd        = '0;
        clear_we   = 1'b0;
        add_we     = 1'b0;
        load_rsp   = 1'b0;
        req_ready  = 1'b0;
        unique case (state_reg)
            dgmst_pkg::ST_CLEAR:
            begin
                clear_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = dgmst_pkg::ST_IDLE;
                end
            end
            dgmst_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req.op)
                        dgmst_pkg::OP_ADD:
                        begin
                            add_we = edge_ok;
                        end
                        dgmst_pkg::OP_RUN:
                        begin
                            cmd.init   = 1'b1;
                            total_next = '0;
                            disc_next  = 1'b0;
                            cnt_next   = '0;
                            state_next = dgmst_pkg::ST_SEARCH;
                        end
                        dgmst_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = dgmst_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = dgmst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dgmst_pkg::ST_SEARCH:
            begin
                // the chain is full once the count has passed every cell
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = dgmst_pkg::ST_SELECT;
                end
            end
            dgmst_pkg::ST_SELECT:
            begin
                priority if (!best_found)
                begin
                    // every active vertex is in the tree
                    state_next = dgmst_pkg::ST_FINISH;
                end
                else if (best_key[KW-1])
                begin
                    // cheapest outside vertex is unreachable
                    disc_next  = 1'b1;
                    state_next = dgmst_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.mark   = 1'b1;
                    total_next = total_sat;
                    state_next = dgmst_pkg::ST_RELAX;
                end
            end
            dgmst_pkg::ST_RELAX:
            begin
                cmd.relax  = 1'b1;
                cnt_next   = '0;
                state_next = dgmst_pkg::ST_SEARCH;
            end
            dgmst_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = dgmst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dgmst_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = load_rsp | (rsp_valid_reg & ~rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dgmst_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            total_reg     <= '0;
            disc_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            disc_reg      <= disc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg.total_weight <= total_reg;
            rsp_reg.disconnected <= disc_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- cell chain ----------------
    assign cf[0] = 1'b0;
    assign ck[0] = '0;
    assign ci[0] = '0;

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        localparam logic [AW-1:0] CELL_IDX = AW'(i);

        logic          cell_we;
        logic [AW-1:0] cell_addr;

        assign active[i] = (n_eff > NW'(i));

        // cell b takes weight(a,b) at row a, cell a takes weight(b,a) at row b
        assign cell_we   = clear_we || (add_we && ((b_addr == CELL_IDX)
                                                   || (a_addr == CELL_IDX)));
        assign cell_addr = clear_we ? cnt_reg
                                    : ((b_addr == CELL_IDX) ? a_addr : b_addr);

        dgmst_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .WEIGHT_BITS  (WEIGHT_BITS),
            .IDX          (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .active        (active[i]),
            .pick          (best_idx),
            .wr_en         (cell_we),
            .wr_addr       (cell_addr),
            .wr_data       (clear_we ? '0 : w_store),
            .cand_found_in (cf[i]),
            .cand_key_in   (ck[i]),
            .cand_idx_in   (ci[i]),
            .cand_found    (cf[i+1]),
            .cand_key      (ck[i+1]),
            .cand_idx      (ci[i+1])
        );
    end

    // ---------------- checks ----------------
    // a committed pick must be one of the vertices in use
    `DGMST_ASSERT_IMP(a_pick_active, clk, rst_n, ((state_reg == dgmst_pkg::ST_SELECT) && best_found), (active[best_idx]))
    // a run starts its first search with a clean total
    `DGMST_ASSERT_NXT(a_run_start, clk, rst_n, ((state_reg == dgmst_pkg::ST_IDLE) && req_valid && (req.op == dgmst_pkg::OP_RUN)), ((state_reg == dgmst_pkg::ST_SEARCH) && (total_reg == '0) && (cnt_reg == '0)))
    // clearing pass ends after the last row
    `DGMST_ASSERT_NXT(a_clear_end, clk, rst_n, ((state_reg == dgmst_pkg::ST_CLEAR) && (cnt_reg == CNT_LAST)), (state_reg == dgmst_pkg::ST_IDLE))
    // a finished run never overwrites an untaken response
    `DGMST_ASSERT_NXT(a_rsp_no_overwrite, clk, rst_n, ((state_reg == dgmst_pkg::ST_FINISH) && rsp_valid_reg && !rsp_ready), (state_reg == dgmst_pkg::ST_FINISH))

endmodule
